// File: rtl/framed_command_parser_top_defines.svh
// assertion macros shared by the checker
`ifndef FRAMED_COMMAND_PARSER_TOP_DEFINES_SVH
`define FRAMED_COMMAND_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define FCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fcp_pkg.sv
`timescale 1ns / 1ps
package fcp_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 64;
   // event queue depth, a power of two so the pointers wrap on their own
   localparam int unsigned EVQ_DEPTH = 4;

   localparam logic [7:0] MAGIC_BYTE            = 8'd170;
   localparam logic [7:0] REPLY_LENGTH          = 8'd2;
   localparam logic [7:0] VERSION_CODE          = 8'd32;
   localparam logic [7:0] REPLY_PUBLISH_VERSION = 8'd3;
   localparam logic [7:0] REPLY_ERROR           = 8'd1;
   localparam logic [7:0] ERR_BAD_MAGIC         = 8'd1;
   localparam logic [7:0] ERR_UNKNOWN_CMD       = 8'd5;

   localparam logic [7:0] CMD_GET_VERSION   = 8'd2;
   localparam logic [7:0] CMD_ANALOG_WRITE  = 8'd6;
   localparam logic [7:0] CMD_DIGITAL_WRITE = 8'd9;
   localparam logic [7:0] CMD_PIN_MODE      = 8'd16;

   localparam logic [1:0] PIN_OP_DIGITAL = 2'd0;
   localparam logic [1:0] PIN_OP_ANALOG  = 2'd1;
   localparam logic [1:0] PIN_OP_MODE    = 2'd2;

   localparam logic OUT_KIND_REPLY  = 1'b0;
   localparam logic OUT_KIND_ACTION = 1'b1;

   typedef enum logic [1:0] {
      EV_BAD_MAGIC,
      EV_VERSION,
      EV_UNKNOWN,
      EV_PIN
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [1:0]  op;
      logic [7:0]  pin;
      logic [7:0]  val;
   } event_type;

   typedef struct packed {
      logic empty;
      logic full;
   } evq_status_type;

endpackage

// File: rtl/fcp_front.sv
`timescale 1ns / 1ps
module fcp_front #(
   parameter int unsigned MAX_PAYLOAD = fcp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   output logic               ev_push,
   output fcp_pkg::event_type ev
);
   import fcp_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 3);
   localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic [POS_W-1:0] pos_ff, pos_in, pos_next;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       cmd_ff, cmd_in, arg1_ff, arg1_in, arg2_ff, arg2_in;
   logic             complete;

   always_comb begin
      pos_next = pos_ff + POS_W'(1);
      pos_in   = pos_next;
      len_in   = len_ff;
      cmd_in   = cmd_ff;
      arg1_in  = arg1_ff;
      arg2_in  = arg2_ff;
      complete = 1'b0;
      ev_push  = 1'b0;
      ev       = '{kind: EV_BAD_MAGIC, op: PIN_OP_DIGITAL, pin: 8'd0, val: 8'd0};

      if (pos_next == POS_W'(1)) begin
         if (rx_byte != MAGIC_BYTE) begin
            pos_in  = '0;
            ev_push = accept;
         end
      end else if (pos_next == POS_W'(2)) begin
         if (rx_byte > MAX_LEN) begin
            // oversized length, dropped silently
            pos_in = '0;
         end else begin
            len_in   = LEN_W'(rx_byte);
            // zero length completes on the length byte itself
            complete = (rx_byte == 8'd0);
         end
      end else begin
         if (pos_next == POS_W'(3)) cmd_in  = rx_byte;
         if (pos_next == POS_W'(4)) arg1_in = rx_byte;
         if (pos_next == POS_W'(5)) arg2_in = rx_byte;
         complete = (pos_next == POS_W'(2) + POS_W'(len_ff));
      end

      if (complete) begin
         ev_push = accept;
         ev.pin  = arg1_in;
         ev.val  = arg2_in;
         unique case (cmd_in)
            CMD_GET_VERSION:   ev.kind = EV_VERSION;
            CMD_DIGITAL_WRITE: begin
               ev.kind = EV_PIN;
               ev.op   = PIN_OP_DIGITAL;
            end
            CMD_ANALOG_WRITE:  begin
               ev.kind = EV_PIN;
               ev.op   = PIN_OP_ANALOG;
            end
            CMD_PIN_MODE:      begin
               ev.kind = EV_PIN;
               ev.op   = PIN_OP_MODE;
            end
            default:           ev.kind = EV_UNKNOWN;
         endcase
         pos_in  = '0;
         cmd_in  = 8'd0;
         arg1_in = 8'd0;
         arg2_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         cmd_ff  <= 8'd0;
         arg1_ff <= 8'd0;
         arg2_ff <= 8'd0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         cmd_ff  <= cmd_in;
         arg1_ff <= arg1_in;
         arg2_ff <= arg2_in;
      end
   end

endmodule

// File: rtl/fcp_event_queue.sv
`timescale 1ns / 1ps
module fcp_event_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fcp_pkg::event_type      push_ev,
   input  logic                    pop,
   output fcp_pkg::event_type      head_ev,
   output fcp_pkg::evq_status_type status
);
   import fcp_pkg::*;

   localparam int unsigned PTR_W = $clog2(EVQ_DEPTH);

   event_type        slot_ff [EVQ_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             do_push, do_pop;

   always_comb begin
      status.empty = (cnt_ff == '0);
      status.full  = (cnt_ff == (PTR_W + 1)'(EVQ_DEPTH));
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_in        = wr_ff + PTR_W'(do_push);
      rd_in        = rd_ff + PTR_W'(do_pop);
      cnt_in       = cnt_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
      head_ev      = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_ev;
   end

endmodule

// File: rtl/fcp_back.sv
`timescale 1ns / 1ps
module fcp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  fcp_pkg::event_type      head_ev,
   input  fcp_pkg::evq_status_type q_status,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output logic                    rsp_out_kind,
   output logic [7:0]              rsp_reply_byte,
   output logic [1:0]              rsp_pin_op,
   output logic [7:0]              rsp_pin_number,
   output logic [7:0]              rsp_pin_value,
   output logic                    rsp_last
);
   import fcp_pkg::*;

   event_type  cur_ff;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic [7:0] b2, b3;

   always_comb begin
      unique case (cur_ff.kind)
         EV_VERSION: begin
            b2 = REPLY_PUBLISH_VERSION;
            b3 = VERSION_CODE;
         end
         EV_UNKNOWN: begin
            b2 = REPLY_ERROR;
            b3 = ERR_UNKNOWN_CMD;
         end
         default:    begin
            b2 = REPLY_ERROR;
            b3 = ERR_BAD_MAGIC;
         end
      endcase

      rsp_empty = !valid_ff;
      if (cur_ff.kind == EV_PIN) begin
         rsp_out_kind   = OUT_KIND_ACTION;
         rsp_reply_byte = 8'd0;
         rsp_pin_op     = cur_ff.op;
         rsp_pin_number = cur_ff.pin;
         rsp_pin_value  = cur_ff.val;
         rsp_last       = 1'b1;
      end else begin
         rsp_out_kind   = OUT_KIND_REPLY;
         rsp_pin_op     = PIN_OP_DIGITAL;
         rsp_pin_number = 8'd0;
         rsp_pin_value  = 8'd0;
         rsp_last       = (idx_ff == 2'd3);
         case (idx_ff)
            2'd0:    rsp_reply_byte = MAGIC_BYTE;
            2'd1:    rsp_reply_byte = REPLY_LENGTH;
            2'd2:    rsp_reply_byte = b2;
            default: rsp_reply_byte = b3;
         endcase
      end

      // take the next event when idle or when the final word leaves
      load     = !valid_ff || (rsp_pop && rsp_last);
      q_pop    = load && !q_status.empty;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = !q_status.empty;
         idx_in   = 2'd0;
      end else if (rsp_pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= head_ev;
   end

endmodule

// File: rtl/framed_command_parser_top.sv
`timescale 1ns / 1ps
// path: a word that completes or breaks a frame passes the event queue and the back's
//   event register to its first result word; further words follow one per cycle if popped
// throughput: one word per cycle while the four-entry event queue has room;
//   results leave one per cycle while popped, so four-word replies set the sustained rate
// reset: synchronous, active high; clears the frame position, kept bytes and queues
module framed_command_parser_top #(
   parameter int unsigned MAX_PAYLOAD = fcp_pkg::MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request side, one received byte per word
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   // response side, oldest result word on the ports while rsp_empty is low
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_reply_byte,
   output logic [1:0] rsp_pin_op,
   output logic [7:0] rsp_pin_number,
   output logic [7:0] rsp_pin_value,
   output logic       rsp_last
);
   import fcp_pkg::*;

   logic           accept;
   logic           ev_push;
   event_type      ev;
   event_type      head_ev;
   evq_status_type q_status;
   logic           q_pop;

   // the front never needs to know whether a byte yields an event, so a
   // full queue simply holds off every byte
   assign req_full = q_status.full;
   assign accept   = req_push && !req_full;

   // front: frame tracking and command classification, one byte per cycle while the queue has room
   fcp_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .ev_push (ev_push),
      .ev      (ev)
   );

   // short queue that decouples parsing from reply expansion
   fcp_event_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (ev_push),
      .push_ev (ev),
      .pop     (q_pop),
      .head_ev (head_ev),
      .status  (q_status)
   );

   // back: expands each event into one pin action or four reply bytes
   fcp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_ev        (head_ev),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_pin_op     (rsp_pin_op),
      .rsp_pin_number (rsp_pin_number),
      .rsp_pin_value  (rsp_pin_value),
      .rsp_last       (rsp_last)
   );

endmodule

// File: rtl/fcp_checker.sv
`timescale 1ns / 1ps
`include "framed_command_parser_top_defines.svh"
module fcp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_out_kind,
   input logic [7:0] rsp_reply_byte,
   input logic [1:0] rsp_pin_op,
   input logic [7:0] rsp_pin_number,
   input logic [7:0] rsp_pin_value,
   input logic       rsp_last
);
   import fcp_pkg::*;

   logic stalled;

   assign stalled = !rsp_empty && !rsp_pop;

   `FCP_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, !rsp_empty && $stable(rsp_reply_byte) && $stable(rsp_out_kind) && $stable(rsp_last), "response word changed while stalled")
   `FCP_ASSERT_NOW(a_action_last, clock, reset, !rsp_empty && rsp_out_kind == OUT_KIND_ACTION, rsp_last && rsp_reply_byte == 8'd0, "pin action not a single last word")
   `FCP_ASSERT_NOW(a_reply_clean, clock, reset, !rsp_empty && rsp_out_kind == OUT_KIND_REPLY, rsp_pin_op == PIN_OP_DIGITAL && rsp_pin_number == 8'd0 && rsp_pin_value == 8'd0, "reply word carries pin fields")
   `FCP_ASSERT_NEXT(a_reply_continues, clock, reset, !rsp_empty && rsp_pop && rsp_out_kind == OUT_KIND_REPLY && !rsp_last, !rsp_empty, "reply stopped before its last byte")

endmodule

bind framed_command_parser_top fcp_checker u_fcp_checker (.*);
